// ===== hw/rtl/wer_pkg.sv =====
package wer_pkg;

    // Register map, index = paddr[3:2]
    localparam logic [1:0] REG_MONITORED_ID = 2'd0;
    localparam logic [1:0] REG_WINDOW_MS    = 2'd1;
    localparam logic [1:0] REG_RATE_LIMIT   = 2'd2;

    localparam int PADDR_W = 4;

    // Register reset values
    localparam logic [31:0] WINDOW_MS_RST  = 32'd1000;
    localparam logic [8:0]  RATE_LIMIT_RST = 9'd10;

    // Field widths
    localparam int ID_W    = 32;
    localparam int TIME_W  = 63;
    localparam int COUNT_W = 9;

    // Largest count the result field can carry
    localparam int COUNT_MAX = 511;

    // One ring entry
    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [ID_W-1:0]   reader;
    } ring_entry_t;

endpackage

// ===== hw/rtl/wer_ram.sv =====
module wer_ram #(
    parameter int WIDTH = 95,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/windowed_event_rate_detector.sv =====
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata: reader_id, target_id, timestamp_ms; tuser: system flag
// m_*      out  m_tvalid/m_tready  tdata: recent_count, alarm; tuser: recorded
// apb      in   psel/penable       monitored_id @0x0, window_ms @0x4, rate_limit @0x8
//
// An event that passes the filter holds the input through the accept, one write into the
// ring memory, one read per entry through its single read port, the drain of the last
// compare, and the load of the result register. A filtered event goes from the accept
// straight to ST_DONE and the load of the result register.
// One event is in work at a time; it waits in ST_DONE while the result register holds a result m_tready has not taken.
// The result register lets the next event start while a result waits on m_tready.
// Reset is immediate: a fill count marks entries not yet written, which read as zero.
module windowed_event_rate_detector
    import wer_pkg::*;
#(
    parameter int RING_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    // input events
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [127:0]        s_tdata,   // [31:0] reader_id, [63:32] target_id,
                                           // [126:64] timestamp_ms, [127] zero
    input  logic                s_tuser,   // [0] reader_is_system
    // results
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [8:0] recent_count, [9] alarm, [15:10] zero
    output logic                m_tuser,   // [0] recorded
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int AW     = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int ENT_W  = $bits(ring_entry_t);

    typedef enum logic [1:0] {ST_IDLE, ST_WRITE, ST_SCAN, ST_DONE} state_t;

    // Configuration registers
    logic [ID_W-1:0]    monitored_id_reg;
    logic [31:0]        window_ms_reg;
    logic [COUNT_W-1:0] rate_limit_reg;

    // Control state
    state_t             state_reg,    state_next;
    logic [AW-1:0]      slot_reg,     slot_next;
    logic [CNT_W-1:0]   fill_reg,     fill_next;
    logic [CNT_W-1:0]   idx_reg,      idx_next;
    logic [CNT_W-1:0]   count_reg,    count_next;
    logic               chk_vld_reg,  chk_vld_next;
    logic               chk_live_reg, chk_live_next;
    logic               rec_reg,      rec_next;
    logic               out_vld_reg,  out_vld_next;
    logic [COUNT_W-1:0] out_cnt_reg,  out_cnt_next;
    logic               out_alm_reg,  out_alm_next;
    logic               out_rec_reg,  out_rec_next;

    // Event payload
    logic [ID_W-1:0]    reader_reg;
    logic [TIME_W-1:0]  now_reg;

    // Memory signals
    logic               ram_we;
    ring_entry_t        ram_wdata;
    ring_entry_t        ram_rdata;
    logic [ENT_W-1:0]   ram_rbits;
    logic [AW-1:0]      ram_raddr;

    // Datapath
    logic               in_acc;
    logic               pass;
    logic               issue;
    logic [ID_W-1:0]    ent_reader;
    logic [TIME_W-1:0]  ent_time;
    logic [63:0]        age;
    logic               hit;
    logic [CMP_W-1:0]   count_ext;
    logic               out_free;
    logic               cfg_wr;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    // Event filter
    assign pass = (monitored_id_reg != '0)
               && (s_tdata[63:32] == monitored_id_reg)
               && (s_tdata[31:0] != s_tdata[63:32])
               && !s_tuser;

    // Ring memory
    assign ram_we    = (state_reg == ST_WRITE);
    assign ram_wdata = '{time_ms: now_reg, reader: reader_reg};
    assign ram_raddr = idx_reg[AW-1:0];
    assign ram_rdata = ring_entry_t'(ram_rbits);

    wer_ram #(
        .WIDTH (ENT_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    // Entry check: unwritten entries read as zero
    assign ent_reader = chk_live_reg ? ram_rdata.reader  : '0;
    assign ent_time   = chk_live_reg ? ram_rdata.time_ms : '0;
    assign age        = {1'b0, now_reg} - {1'b0, ent_time};
    assign hit        = (ent_reader == reader_reg)
                     && (age[63] || (age <= {32'd0, window_ms_reg}));

    assign issue     = (idx_reg != CNT_W'(RING_DEPTH));
    assign count_ext = CMP_W'(count_reg);

    // Sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        fill_next     = fill_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        chk_vld_next  = 1'b0;
        chk_live_next = 1'b0;
        rec_next      = rec_reg;
        out_vld_next  = out_vld_reg && !m_tready;
        out_cnt_next  = out_cnt_reg;
        out_alm_next  = out_alm_reg;
        out_rec_next  = out_rec_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    count_next = '0;
                    rec_next   = pass;
                    state_next = pass ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE:
            begin
                slot_next  = (slot_reg == AW'(RING_DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                fill_next  = (fill_reg == CNT_W'(RING_DEPTH)) ? fill_reg : fill_reg + 1'b1;
                idx_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    chk_vld_next  = 1'b1;
                    chk_live_next = (idx_reg < fill_reg);
                    idx_next      = idx_reg + 1'b1;
                end
                if (chk_vld_reg && hit)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (!issue && !chk_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    out_rec_next = rec_reg;
                    out_cnt_next = (count_ext > CMP_W'(COUNT_MAX))
                                 ? COUNT_W'(COUNT_MAX) : count_ext[COUNT_W-1:0];
                    out_alm_next = (count_ext > CMP_W'(rate_limit_reg));
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            slot_reg     <= '0;
            fill_reg     <= '0;
            idx_reg      <= '0;
            count_reg    <= '0;
            chk_vld_reg  <= 1'b0;
            chk_live_reg <= 1'b0;
            rec_reg      <= 1'b0;
            out_vld_reg  <= 1'b0;
            out_cnt_reg  <= '0;
            out_alm_reg  <= 1'b0;
            out_rec_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            fill_reg     <= fill_next;
            idx_reg      <= idx_next;
            count_reg    <= count_next;
            chk_vld_reg  <= chk_vld_next;
            chk_live_reg <= chk_live_next;
            rec_reg      <= rec_next;
            out_vld_reg  <= out_vld_next;
            out_cnt_reg  <= out_cnt_next;
            out_alm_reg  <= out_alm_next;
            out_rec_reg  <= out_rec_next;
        end
    end

    // Event payload capture
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            reader_reg <= s_tdata[31:0];
            now_reg    <= s_tdata[126:64];
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_rec_reg;
    assign m_tdata  = {6'd0, out_alm_reg, out_cnt_reg};

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            monitored_id_reg <= '0;
            window_ms_reg    <= WINDOW_MS_RST;
            rate_limit_reg   <= RATE_LIMIT_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MONITORED_ID: monitored_id_reg <= pwdata;
                REG_WINDOW_MS:    window_ms_reg    <= pwdata;
                REG_RATE_LIMIT:   rate_limit_reg   <= pwdata[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MONITORED_ID: prdata = monitored_id_reg;
            REG_WINDOW_MS:    prdata = window_ms_reg;
            REG_RATE_LIMIT:   prdata = {23'd0, rate_limit_reg};
            default:          prdata = '0;
        endcase
    end

`ifndef SYNTHESIS
    // Scan never counts more entries than it has read
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (count_reg <= idx_reg))
        else $error("count exceeds entries scanned");

    // A ring write always leaves at least one live entry
    a_fill_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> (fill_reg != '0))
        else $error("fill count zero after ring write");

    // An ignored event reports no count and no alarm
    a_ignored_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata[9:0] == '0))
        else $error("ignored event carries a count");

    // A filtered event goes straight to the result stage
    a_filtered_path: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !pass) |=> (state_reg == ST_DONE && count_reg == '0))
        else $error("filtered event entered the scan");
`endif

endmodule

// ===== tb/sv/tb_windowed_event_rate_detector.sv =====
module tb_windowed_event_rate_detector;
    timeunit 1ns;
    timeprecision 1ps;

    import wer_pkg::*;

    localparam int HIST_DEPTH      = 256;
    localparam int CYCLE_LIMIT     = 4_000_000;
    localparam int RANDOM_RECORDED = 1200;
    localparam int HOLD_CYCLES     = 1500;
    localparam int DRAIN_CYCLES    = 300;

    // index with no register behind it
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic               recorded;
        logic [COUNT_W-1:0] count;
        logic               alarm;
    } rate_result_t;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [127:0]        s_tdata  = '0;   // [31:0] reader_id, [63:32] target_id,
                                          // [126:64] timestamp_ms, [127] zero
    logic                s_tuser  = 1'b0; // [0] reader_is_system
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [15:0]         m_tdata;         // [8:0] recent_count, [9] alarm, [15:10] zero
    logic                m_tuser;         // [0] recorded
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;

    // predictor state: event history and register shadows
    logic [ID_W-1:0]     hist_reader [HIST_DEPTH];
    logic [63:0]         hist_time   [HIST_DEPTH];
    int unsigned         hist_slot;
    logic [31:0]         shadow_monitored;
    logic [31:0]         shadow_window;
    logic [COUNT_W-1:0]  shadow_limit;

    rate_result_t        pending_rates [$];
    rate_result_t        want_res;
    int                  mismatch_count = 0;
    int                  recorded_sent  = 0;
    int                  cycle_count    = 0;
    bit                  tx_steady      = 1'b0;
    bit                  rx_steady      = 1'b0;
    bit                  hold_req       = 1'b0;

    windowed_event_rate_detector #(.RING_DEPTH(HIST_DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_windowed_event_rate_detector: errors");
            $finish;
        end
    end

    // Filter the event, log it in the history and count same-reader entries in the window
    function automatic rate_result_t predict_rate(input logic [ID_W-1:0] rd,
                                                  input logic [ID_W-1:0] tg,
                                                  input logic sys,
                                                  input logic [TIME_W-1:0] ts);
        rate_result_t res;
        logic [63:0]  age;
        int unsigned  hits;
        res  = '0;
        hits = 0;
        if (shadow_monitored == 0 || tg != shadow_monitored || rd == tg || sys)
            return res;
        hist_reader[hist_slot] = rd;
        hist_time[hist_slot]   = {1'b0, ts};
        hist_slot = (hist_slot + 1) % HIST_DEPTH;
        for (int k = 0; k < HIST_DEPTH; k++)
        begin
            if (hist_reader[k] == rd)
            begin
                // negative age (entry from the future) always counts
                age = {1'b0, ts} - hist_time[k];
                if (age[63] || age <= {32'd0, shadow_window})
                    hits++;
            end
        end
        res.recorded = 1'b1;
        res.count    = COUNT_W'((hits > COUNT_MAX) ? COUNT_MAX : hits);
        res.alarm    = (hits > shadow_limit);
        return res;
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[TIME_W-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_rates.size() == 0)
            begin
                $error("result item with none pending: tdata %h tuser %b", m_tdata, m_tuser);
                mismatch_count++;
            end
            else
            begin
                want_res = pending_rates.pop_front();
                if (m_tuser !== want_res.recorded)
                begin
                    $error("recorded: expected %0d, got %0d", want_res.recorded, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[8:0] !== want_res.count)
                begin
                    $error("recent_count: expected %0d, got %0d",
                           want_res.count, m_tdata[8:0]);
                    mismatch_count++;
                end
                if (m_tdata[9] !== want_res.alarm)
                begin
                    $error("alarm: expected %0d, got %0d", want_res.alarm, m_tdata[9]);
                    mismatch_count++;
                end
            end
        end
    end

    // result sink: random stalls, quiet stretches, and a long hold-off on request
    initial
    begin
        int r;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!rx_steady && r < 2)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(20, 150)) @(posedge clk);
            end
            else if (!rx_steady && r < 25)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Offer one event and log its expected result once the block takes it
    task automatic send_event(input logic [ID_W-1:0] rd, input logic [ID_W-1:0] tg,
                              input logic sys, input logic [TIME_W-1:0] ts);
        rate_result_t want;
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, ts, tg, rd};
        s_tuser  <= sys;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        want = predict_rate(rd, tg, sys, ts);
        pending_rates.push_back(want);
        if (want.recorded)
            recorded_sent++;
    endtask

    task automatic idle_events(input int n);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_rates.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one APB transfer: setup cycle, access cycle, then back to idle
    task automatic apb_access(input logic wr, input logic [1:0] idx,
                              input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] unused;
        apb_access(1'b1, idx, value, unused);
        case (idx)
            REG_MONITORED_ID: shadow_monitored = value;
            REG_WINDOW_MS:    shadow_window    = value;
            REG_RATE_LIMIT:   shadow_limit     = value[COUNT_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [31:0] want,
                             input string name);
        logic [31:0] got;
        apb_access(1'b0, idx, 32'd0, got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatch_count++;
        end
    endtask

    // reprogram all registers once the block is idle, then read them back
    task automatic apply_settings(input logic [31:0] mon, input logic [31:0] win,
                                  input logic [COUNT_W-1:0] lim);
        idle_events(1);
        wait_drained();
        write_reg(REG_MONITORED_ID, mon);
        write_reg(REG_WINDOW_MS, win);
        write_reg(REG_RATE_LIMIT, 32'(lim));
        check_reg(REG_MONITORED_ID, shadow_monitored, "monitored_id");
        check_reg(REG_WINDOW_MS, shadow_window, "window_ms");
        check_reg(REG_RATE_LIMIT, 32'(shadow_limit), "rate_limit");
    endtask

    // Out of reset: default registers, tracking disabled
    task automatic test_reset_defaults();
        check_reg(REG_MONITORED_ID, 32'd0, "monitored_id");
        check_reg(REG_WINDOW_MS, WINDOW_MS_RST, "window_ms");
        check_reg(REG_RATE_LIMIT, 32'(RATE_LIMIT_RST), "rate_limit");
        send_event(32'd5, 32'd0, 1'b0, '0);
        send_event(32'd0, 32'hFFFF_FFFF, 1'b1, 63'h7FFF_FFFF_FFFF_FFFF);
    endtask

    // The target, self-event and system filter rules, then reader zero against a ring that was never written
    task automatic test_filter_cases();
        apply_settings(32'hFFFF_FFFF, 32'd1000, 9'd10);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        send_event(32'd1, 32'hFFFF_FFFE, 1'b0, 63'd10);
        send_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 63'd10);
        send_event(32'd2, 32'hFFFF_FFFF, 1'b1, 63'd10);
        send_event(32'd0, 32'hFFFF_FFFF, 1'b0, 63'd0);
    endtask

    // Zero and full windows, future entries, time extremes, limit extremes
    task automatic test_window_edges();
        apply_settings(32'h8000_0001, 32'd0, 9'd0);
        send_event(32'd7, 32'h8000_0001, 1'b0, 63'd100);
        send_event(32'd7, 32'h8000_0001, 1'b0, 63'd100);
        send_event(32'd7, 32'h8000_0001, 1'b0, 63'd101);
        send_event(32'd7, 32'h8000_0001, 1'b0, 63'd50);
        send_event(32'd7, 32'h8000_0001, 1'b0, 63'h7FFF_FFFF_FFFF_FFFF);
        apply_settings(32'h8000_0001, 32'hFFFF_FFFF, 9'd256);
        send_event(32'hFFFF_FFFF, 32'h8000_0001, 1'b0, 63'd0);
        send_event(32'd7, 32'h8000_0001, 1'b0, 63'd4294967395);
        send_event(32'd0, 32'h8000_0001, 1'b0, 63'd0);
    endtask

    // Results held back long enough that the block stalls its input
    task automatic test_backpressure();
        idle_events(1);
        wait_drained();
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            if (i % 3 == 0)
                send_event(32'h1234, shadow_monitored ^ 32'd1, 1'b0, 63'(1000 + i));
            else
                send_event(32'h1234 + i % 2, shadow_monitored, 1'b0, 63'(1000 + 3 * i));
        end
        idle_events(1);
        wait_drained();
    endtask

    // Bursty traffic from a small reader pool, with noise and broken events mixed in
    task automatic run_random_phase(input int want_recorded, input int max_items);
        logic [ID_W-1:0]   pool [4];
        logic [TIME_W-1:0] now_ms;
        logic [ID_W-1:0]   rd;
        logic [ID_W-1:0]   tg;
        logic              sys;
        int                sel;
        int                r;
        int                items;
        int                base_rec;
        pool[0] = $urandom_range(1, 8);
        pool[1] = $urandom;
        pool[2] = $urandom_range(0, 3);
        pool[3] = 32'hFFFF_FFFF;
        for (int k = 0; k < 4; k++)
            if (pool[k] == shadow_monitored)
                pool[k] ^= 32'd1;
        now_ms   = ($urandom_range(0, 1) != 0) ? rand_time() : 63'($urandom_range(0, 5000));
        items    = 0;
        base_rec = recorded_sent;
        while (recorded_sent - base_rec < want_recorded && items < max_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                now_ms += 63'($urandom_range(0, 40));
            else if (r < 80)
                now_ms -= 63'($urandom_range(0, 500));
            else if (r < 92)
                now_ms += 63'($urandom_range(0, 5000));
            else
                now_ms = rand_time();
            sel = $urandom_range(0, 99);
            rd  = pool[$urandom_range(0, 3)];
            tg  = shadow_monitored;
            sys = 1'b0;
            if (sel >= 82 && sel < 88)
            begin
                rd  = $urandom;
                tg  = $urandom;
                sys = 1'($urandom_range(0, 1));
            end
            else if (sel >= 88 && sel < 94)
                rd = shadow_monitored;
            else if (sel >= 94)
                sys = 1'b1;
            send_event(rd, tg, sys, now_ms);
            items++;
            if ($urandom_range(0, 199) == 0)
            begin
                idle_events(1);
                wait_drained();
            end
            else
                idle_events(tx_steady ? 0 : pick_gap());
        end
    endtask

    task automatic test_random_traffic();
        int phase;
        int base_rec;
        phase    = 0;
        base_rec = recorded_sent;
        while (recorded_sent - base_rec < RANDOM_RECORDED)
        begin
            case (phase % 6)
                0: apply_settings($urandom, 32'd1000, 9'd10);
                1: apply_settings(32'hFFFF_FFFF, 32'd0, 9'd0);
                2: apply_settings($urandom | 32'd1, 32'hFFFF_FFFF, 9'd256);
                3: apply_settings(32'd1, $urandom_range(20, 400),
                                  9'($urandom_range(0, 256)));
                4: apply_settings($urandom, $urandom, 9'($urandom_range(1, 40)));
                default: apply_settings(32'd0, $urandom_range(0, 2000), 9'd255);
            endcase
            tx_steady = (phase % 3 == 2);
            rx_steady = (phase % 3 == 2);
            if (phase % 6 == 5)
                run_random_phase(1, 30);
            else
                run_random_phase(250, 600);
            phase++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    initial
    begin
        for (int k = 0; k < HIST_DEPTH; k++)
        begin
            hist_reader[k] = '0;
            hist_time[k]   = '0;
        end
        hist_slot        = 0;
        shadow_monitored = 32'd0;
        shadow_window    = WINDOW_MS_RST;
        shadow_limit     = RATE_LIMIT_RST;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_filter_cases();
        test_window_edges();
        test_backpressure();
        test_random_traffic();

        idle_events(1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_windowed_event_rate_detector: clean");
        else
            $display("tb_windowed_event_rate_detector: errors");
        $finish;
    end

endmodule
